FILE: hw/rtl/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared types and command codes of the I2C master byte engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbe_pkg;

   localparam logic [3:0] KIND_TICK     = 4'd0;
   localparam logic [3:0] KIND_START    = 4'd1;
   localparam logic [3:0] KIND_RESTART  = 4'd2;
   localparam logic [3:0] KIND_STOP     = 4'd3;
   localparam logic [3:0] KIND_WRITE    = 4'd4;
   localparam logic [3:0] KIND_READ     = 4'd5;
   localparam logic [3:0] KIND_RSTRETCH = 4'd6;
   localparam logic [3:0] KIND_CHKACK   = 4'd7;
   localparam logic [3:0] KIND_SACK     = 4'd8;
   localparam logic [3:0] KIND_SNACK    = 4'd9;
   localparam logic [3:0] KIND_WAIT     = 4'd10;

   localparam logic REG_PHASE_TICKS = 1'b0;

   typedef struct packed {
      logic [3:0] kind;
      logic [7:0] data;
      logic       sda_in;
      logic       scl_in;
   } item_type;

   typedef struct packed {
      logic       scl_out;
      logic       sda_out;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       ack_received;
      logic       rejected;
   } result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/i2cmbe_csr.sv
// ----------------------------------------------------------------------------
// i2cmbe_csr
// APB-style register port holding the phase length in ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbe_csr
   import i2cmbe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready,
   output logic      [7:0]  phase_ticks
);

   logic [7:0] phase_ticks_ff;
   logic [7:0] phase_ticks_in;
   logic       wr_en;

   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      phase_ticks_in = phase_ticks_ff;
      if (wr_en && (csr_paddr[2] == REG_PHASE_TICKS)) begin
         phase_ticks_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff <= 8'd1;
      end else begin
         phase_ticks_ff <= phase_ticks_in;
      end
   end

   always_comb begin
      csr_prdata = 32'd0;
      if (csr_paddr[2] == REG_PHASE_TICKS) begin
         csr_prdata = {24'd0, phase_ticks_ff};
      end
   end

   assign csr_pready  = 1'b1;
   assign phase_ticks = phase_ticks_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/i2cmbe_seq.sv
// ----------------------------------------------------------------------------
// i2cmbe_seq
// Pin phase sequencer: command decode, phase timing, SDA sampling and drives.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cmbe_seq
   import i2cmbe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire item_type   item,
   input  wire logic [7:0] phase_ticks,
   output result_type      result
);

   logic [3:0] cmd_ff, cmd_in;
   logic [4:0] step_ff, step_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] timer_ff, timer_in;
   logic       scl_drv_ff, scl_drv_in;
   logic       sda_drv_ff, sda_drv_in;
   logic       ack_ff, ack_in;
   logic [7:0] rd_byte_ff, rd_byte_in;

   logic [7:0] pt;
   logic       busy;
   logic [7:0] timer_inc;
   logic [4:0] step_inc;
   logic [7:0] shift_smp;
   logic [7:0] shift_start;
   logic [1:0] drive;
   logic       done;
   logic       rej;
   logic [4:0] step_lim;

   function automatic logic [4:0] phase_count(input logic [3:0] cmd);
      logic [4:0] n;
      case (cmd)
         KIND_WRITE:    n = 5'd18;
         KIND_READ:     n = 5'd16;
         KIND_RSTRETCH: n = 5'd15;
         KIND_CHKACK:   n = 5'd2;
         KIND_WAIT:     n = 5'd1;
         default:       n = 5'd3;
      endcase
      return n;
   endfunction

   function automatic logic samples(input logic [3:0] cmd, input logic [4:0] s);
      logic r;
      case (cmd)
         KIND_READ:     r = !s[0];
         KIND_RSTRETCH: r = (s == 5'd0) || s[0];
         KIND_CHKACK:   r = (s == 5'd0);
         default:       r = 1'b0;
      endcase
      return r;
   endfunction

   // returns {scl, sda}
   function automatic logic [1:0] phase_drive(input logic [3:0] cmd, input logic [4:0] s,
                                              input logic [7:0] sh, input logic sda_prev);
      logic       c;
      logic       d;
      logic [4:0] sm1;
      logic [2:0] bit_idx;
      c       = 1'b0;
      d       = 1'b1;
      sm1     = s - 5'd1;
      bit_idx = 3'd7 - sm1[3:1];
      case (cmd) inside
         KIND_START, KIND_RESTART: begin
            c = (s == 5'd0) || (s == 5'd1);
            d = (s == 5'd0);
         end
         KIND_STOP: begin
            c = (s != 5'd0);
            d = (s == 5'd2);
         end
         KIND_WRITE: begin
            if (s == 5'd0) begin
               c = 1'b0;
               d = 1'b0;
            end else if (s >= 5'd17) begin
               c = 1'b0;
               d = sh[0];
            end else begin
               c = !s[0];
               d = sh[bit_idx];
            end
         end
         KIND_READ:     c = !s[0];
         KIND_RSTRETCH: c = s[0];
         KIND_CHKACK:   c = (s == 5'd0);
         KIND_SACK: begin
            c = (s == 5'd1);
            d = 1'b0;
         end
         KIND_SNACK:    c = (s == 5'd1);
         default: begin
            c = 1'b1;
            d = sda_prev;
         end
      endcase
      return {c, d};
   endfunction

   assign pt          = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
   assign busy        = (cmd_ff != KIND_TICK);
   assign timer_inc   = (timer_ff < pt) ? timer_ff + 8'd1 : timer_ff;
   assign step_inc    = step_ff + 5'd1;
   assign step_lim    = phase_count(cmd_ff);
   assign shift_start = (item.kind == KIND_WRITE) ? item.data : 8'd0;

   always_comb begin
      cmd_in     = cmd_ff;
      step_in    = step_ff;
      shift_in   = shift_ff;
      timer_in   = timer_ff;
      scl_drv_in = scl_drv_ff;
      sda_drv_in = sda_drv_ff;
      ack_in     = ack_ff;
      rd_byte_in = rd_byte_ff;
      shift_smp  = shift_ff;
      drive      = {scl_drv_ff, sda_drv_ff};
      done       = 1'b0;
      rej        = 1'b0;
      if (item.kind == KIND_TICK) begin
         if (busy) begin
            timer_in = timer_inc;
            if ((timer_inc >= pt) && !((cmd_ff == KIND_WAIT) && !item.scl_in)) begin
               if (samples(cmd_ff, step_ff)) begin
                  if (cmd_ff == KIND_CHKACK) begin
                     ack_in = !item.sda_in;
                  end else begin
                     shift_smp = {shift_ff[6:0], item.sda_in};
                  end
               end
               shift_in = shift_smp;
               timer_in = 8'd0;
               if (step_inc >= step_lim) begin
                  if ((cmd_ff == KIND_READ) || (cmd_ff == KIND_RSTRETCH)) begin
                     rd_byte_in = shift_smp;
                  end
                  done    = 1'b1;
                  cmd_in  = KIND_TICK;
                  step_in = 5'd0;
               end else begin
                  step_in    = step_inc;
                  drive      = phase_drive(cmd_ff, step_inc, shift_smp, sda_drv_ff);
                  scl_drv_in = drive[1];
                  sda_drv_in = drive[0];
               end
            end
         end
      end else if (item.kind <= KIND_WAIT) begin
         if (busy) begin
            rej = 1'b1;
         end else begin
            cmd_in     = item.kind;
            step_in    = 5'd0;
            timer_in   = 8'd0;
            shift_in   = shift_start;
            drive      = phase_drive(item.kind, 5'd0, shift_start, sda_drv_ff);
            scl_drv_in = drive[1];
            sda_drv_in = drive[0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff     <= KIND_TICK;
         step_ff    <= 5'd0;
         shift_ff   <= 8'd0;
         timer_ff   <= 8'd0;
         scl_drv_ff <= 1'b1;
         sda_drv_ff <= 1'b1;
         ack_ff     <= 1'b0;
         rd_byte_ff <= 8'd0;
      end else if (advance) begin
         cmd_ff     <= cmd_in;
         step_ff    <= step_in;
         shift_ff   <= shift_in;
         timer_ff   <= timer_in;
         scl_drv_ff <= scl_drv_in;
         sda_drv_ff <= sda_drv_in;
         ack_ff     <= ack_in;
         rd_byte_ff <= rd_byte_in;
      end
   end

   always_comb begin
      result.scl_out      = scl_drv_in;
      result.sda_out      = sda_drv_in;
      result.busy_res     = (cmd_in != KIND_TICK);
      result.done_res     = done;
      result.read_data    = rd_byte_in;
      result.ack_received = ack_in;
      result.rejected     = rej;
   end

`ifndef SYNTHESIS
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (cmd_ff == KIND_TICK) |-> ((step_ff == 5'd0) && (timer_ff == 8'd0)))
      else $error("idle sequencer holds a stale step or timer");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      (cmd_ff != KIND_TICK) |-> (step_ff < step_lim))
      else $error("phase step past end of command");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (advance && done) |-> (cmd_in == KIND_TICK))
      else $error("completed beat leaves sequencer busy");

   a_reject_keeps: assert property (@(posedge clock) disable iff (reset)
      (advance && rej) |=> ((cmd_ff == $past(cmd_ff)) && (step_ff == $past(step_ff))))
      else $error("rejected command disturbed the running sequence");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/i2c_master_byte_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// rsp_valid rises after the req beat passes the input and result registers,
// and the result register stalls while rsp_ready is low; one beat per cycle
// sustained while rsp_ready is high, set by the sequencer update between the two.
// Synchronous reset: idle, drives released, phase_ticks = 1, no results held.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_byte_engine
   import i2cmbe_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_kind,
   input  wire logic [7:0]  req_data,
   input  wire logic        req_sda_in,
   input  wire logic        req_scl_in,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_scl_out,
   output logic             rsp_sda_out,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic      [7:0]  rsp_read_data,
   output logic             rsp_ack_received,
   output logic             rsp_rejected,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff, s1_item_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       s1_fire;
   logic [7:0] phase_ticks;
   result_type seq_result;

   i2cmbe_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .phase_ticks (phase_ticks)
   );

   i2cmbe_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .advance     (s1_fire),
      .item        (s1_item_ff),
      .phase_ticks (phase_ticks),
      .result      (seq_result)
   );

   assign s1_fire   = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_fire;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_item_in   = s1_item_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (req_valid && req_ready) begin
         s1_valid_in       = 1'b1;
         s1_item_in.kind   = req_kind;
         s1_item_in.data   = req_data;
         s1_item_in.sda_in = req_sda_in;
         s1_item_in.scl_in = req_scl_in;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
      if (s1_fire) begin
         out_valid_in = 1'b1;
         out_in       = seq_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
      s1_item_ff <= s1_item_in;
      out_ff     <= out_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_scl_out      = out_ff.scl_out;
   assign rsp_sda_out      = out_ff.sda_out;
   assign rsp_busy_res     = out_ff.busy_res;
   assign rsp_done_res     = out_ff.done_res;
   assign rsp_read_data    = out_ff.read_data;
   assign rsp_ack_received = out_ff.ack_received;
   assign rsp_rejected     = out_ff.rejected;

endmodule

`default_nettype wire
